// File: rtl/msto_pkg.sv
// Package for the multi-slot timeout table: shared types, codes and constants.
// Used by the controller, the datapath and the top level. Depends on nothing.
package msto_pkg;

    // Input operation codes carried in tuser.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ARM  = 1'b1;

    // Result kind codes carried in tuser.
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // Field widths fixed by the stream format.
    localparam int DUR_W  = 32;
    localparam int HND_W  = 16;
    localparam int TAG_W  = 32;
    localparam int SLOT_W = 2;

    // At most this many expiry events are reported per tick.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // latch the incoming word, start at slot 0
        logic advance;      // move to the next slot
        logic arm_commit;   // write the item into the current slot, reply accepted
        logic arm_fail;     // reply with the table full
        logic tick_commit;  // decrement the current slot, capture an expiry
        logic flush_emit;   // send the held expiry as the last event
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_arm;     // the latched word is an arm request
        logic idx_last;     // the current slot is the highest one
        logic slot_free;    // the current slot is free
        logic tick_hit;     // the current slot expires and reports on this tick
        logic pend_vld;     // an expiry event is held back
        logic out_free;     // the output register can take a word this cycle
    } stat_t;

endpackage

// File: rtl/msto_ctrl.sv
// Controller of the multi-slot timeout table: sequences the slot scan.
// Depends on msto_pkg for the state type and the command and status structs.
module msto_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  msto_pkg::stat_t stat,
    output msto_pkg::cmd_t  cmd
);

    msto_pkg::ctl_state_t state_reg;
    msto_pkg::ctl_state_t state_next;
    logic                 tick_stall;

    // A new expiry cannot be held while the previous one still waits for the output.
    assign tick_stall = stat.tick_hit && stat.pend_vld && !stat.out_free;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msto_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msto_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = msto_pkg::ST_SCAN;
                end
            end
            msto_pkg::ST_SCAN:
            begin
                if (stat.item_arm)
                begin
                    if ((stat.slot_free || stat.idx_last) && stat.out_free)
                    begin
                        state_next = msto_pkg::ST_IDLE;
                    end
                end
                else if (!tick_stall && stat.idx_last)
                begin
                    if (stat.pend_vld || stat.tick_hit)
                    begin
                        state_next = msto_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = msto_pkg::ST_IDLE;
                    end
                end
            end
            msto_pkg::ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = msto_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msto_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            msto_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            msto_pkg::ST_SCAN:
            begin
                if (stat.item_arm)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.arm_commit = stat.out_free;
                    end
                    else if (stat.idx_last)
                    begin
                        cmd.arm_fail = stat.out_free;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else if (!tick_stall)
                begin
                    cmd.tick_commit = 1'b1;
                    cmd.advance     = !stat.idx_last;
                end
            end
            msto_pkg::ST_FLUSH:
            begin
                cmd.flush_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/msto_dpath.sv
// Datapath of the multi-slot timeout table: slot memories, busy bits,
// held expiry event and output register. Depends on msto_pkg.
module msto_dpath
#(
    parameter int SLOTS = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  msto_pkg::cmd_t             cmd,
    output msto_pkg::stat_t            stat,
    input  logic                       in_func,
    input  logic [msto_pkg::DUR_W-1:0] in_duration,
    input  logic [msto_pkg::HND_W-1:0] in_handler,
    input  logic [msto_pkg::TAG_W-1:0] in_tag,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_kind,
    output logic                       out_accepted,
    output logic [msto_pkg::SLOT_W-1:0] out_slot,
    output logic [msto_pkg::HND_W-1:0] out_handler,
    output logic [msto_pkg::TAG_W-1:0] out_tag,
    output logic                       out_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot memories; entries are used only while their busy bit is set.
    logic [msto_pkg::DUR_W-1:0] rem_mem [SLOTS];
    logic [msto_pkg::HND_W-1:0] hnd_mem [SLOTS];
    logic [msto_pkg::TAG_W-1:0] tag_mem [SLOTS];

    logic [msto_pkg::DUR_W-1:0] rem_q_reg;
    logic [msto_pkg::HND_W-1:0] hnd_q_reg;
    logic [msto_pkg::TAG_W-1:0] tag_q_reg;

    // Latched item.
    logic                       func_reg;
    logic [msto_pkg::DUR_W-1:0] dur_reg;
    logic [msto_pkg::HND_W-1:0] hnd_reg;
    logic [msto_pkg::TAG_W-1:0] tag_reg;

    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic [IDX_W+1:0]           idx_ext;
    logic [msto_pkg::SLOT_W-1:0] idx_lo;
    logic [SLOTS-1:0]           busy_reg;
    logic [SLOTS-1:0]           busy_next;
    logic                       cur_busy;
    logic [msto_pkg::DUR_W-1:0] rem_dec;
    logic                       rem_we;
    logic [msto_pkg::DUR_W-1:0] rem_wdata;
    logic                       tick_hit;

    // Held expiry event and its count.
    logic [msto_pkg::CNT_W-1:0] cnt_reg;
    logic                       pend_vld_reg;
    logic [msto_pkg::SLOT_W-1:0] pend_slot_reg;
    logic [msto_pkg::HND_W-1:0] pend_hnd_reg;
    logic [msto_pkg::TAG_W-1:0] pend_tag_reg;
    logic                       pend_push;

    // Output register.
    logic                       out_vld_reg;
    logic                       out_free;
    logic                       out_load;
    logic                       out_kind_reg;
    logic                       out_acc_reg;
    logic [msto_pkg::SLOT_W-1:0] out_slot_reg;
    logic [msto_pkg::HND_W-1:0] out_hnd_reg;
    logic [msto_pkg::TAG_W-1:0] out_tag_reg;
    logic                       out_last_reg;

    // Slot index: restart on a new word, step on advance.
    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign idx_ext  = {2'b00, idx_reg};
    assign idx_lo   = idx_ext[msto_pkg::SLOT_W-1:0];
    assign cur_busy = busy_reg[idx_reg];
    assign rem_dec  = rem_q_reg - msto_pkg::DUR_W'(1);
    assign tick_hit = cur_busy && (rem_q_reg == msto_pkg::DUR_W'(1))
                      && (hnd_q_reg != '0)
                      && (cnt_reg < msto_pkg::CNT_W'(msto_pkg::MAX_RESULTS));
    assign pend_push = cmd.tick_commit && tick_hit;

    // Remaining-count write: the new duration on arm, the decrement on tick.
    assign rem_we    = cmd.arm_commit || (cmd.tick_commit && cur_busy);
    assign rem_wdata = cmd.arm_commit ? dur_reg : rem_dec;

    // Slot memories with registered read at the next index.
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[idx_reg] <= rem_wdata;
        end
        if (cmd.arm_commit)
        begin
            hnd_mem[idx_reg] <= hnd_reg;
            tag_mem[idx_reg] <= tag_reg;
        end
        rem_q_reg <= rem_mem[idx_next];
        hnd_q_reg <= hnd_mem[idx_next];
        tag_q_reg <= tag_mem[idx_next];
    end

    // Busy bits: a slot is busy while its remaining count is not zero.
    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.arm_commit)
        begin
            busy_next[idx_reg] = (dur_reg != '0);
        end
        else if (cmd.tick_commit && cur_busy && (rem_dec == '0))
        begin
            busy_next[idx_reg] = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            busy_reg     <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            if (cmd.load)
            begin
                cnt_reg      <= '0;
                pend_vld_reg <= 1'b0;
            end
            else if (pend_push)
            begin
                cnt_reg      <= cnt_reg + msto_pkg::CNT_W'(1);
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.flush_emit)
            begin
                pend_vld_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Item and held-event payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            dur_reg  <= in_duration;
            hnd_reg  <= in_handler;
            tag_reg  <= in_tag;
        end
        if (pend_push)
        begin
            pend_slot_reg <= idx_lo;
            pend_hnd_reg  <= hnd_q_reg;
            pend_tag_reg  <= tag_q_reg;
        end
    end

    // Output register load: arm replies, an earlier event pushed out by a
    // newer one, or the held event at the end of the scan.
    assign out_free = !out_vld_reg || out_ready;
    assign out_load = cmd.arm_commit || cmd.arm_fail || cmd.flush_emit
                      || (pend_push && pend_vld_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.arm_commit || cmd.arm_fail)
        begin
            out_kind_reg <= msto_pkg::KIND_REPLY;
            out_acc_reg  <= cmd.arm_commit;
            out_slot_reg <= cmd.arm_commit ? idx_lo : '0;
            out_hnd_reg  <= '0;
            out_tag_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        else if (out_load)
        begin
            out_kind_reg <= msto_pkg::KIND_EVENT;
            out_acc_reg  <= 1'b0;
            out_slot_reg <= pend_slot_reg;
            out_hnd_reg  <= pend_hnd_reg;
            out_tag_reg  <= pend_tag_reg;
            out_last_reg <= cmd.flush_emit;
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_kind     = out_kind_reg;
    assign out_accepted = out_acc_reg;
    assign out_slot     = out_slot_reg;
    assign out_handler  = out_hnd_reg;
    assign out_tag      = out_tag_reg;
    assign out_last     = out_last_reg;

    // Status to the controller.
    assign stat.item_arm  = (func_reg == msto_pkg::FUNC_ARM);
    assign stat.idx_last  = (idx_reg == IDX_W'(SLOTS - 1));
    assign stat.slot_free = !cur_busy;
    assign stat.tick_hit  = tick_hit;
    assign stat.pend_vld  = pend_vld_reg;
    assign stat.out_free  = out_free;

    // A held event is only replaced when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pend_push && pend_vld_reg |-> out_free)
        else $error("held expiry event pushed into a full output register");

    // Replies and the final event are only issued with room at the output.
    a_reply_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.arm_commit || cmd.arm_fail || cmd.flush_emit) |-> out_free)
        else $error("result issued while the output register is full");

    // The event count per tick stays within the limit.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= msto_pkg::CNT_W'(msto_pkg::MAX_RESULTS))
        else $error("expiry event count above the limit");

    // Arming with a nonzero duration marks the slot busy.
    a_arm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arm_commit && (dur_reg != '0) |=> busy_reg[$past(idx_reg)])
        else $error("armed slot not marked busy");

endmodule

// File: rtl/multi_slot_timeout_table_top.sv
// Top level of the multi-slot timeout table: stream ports and field packing.
// Depends on msto_pkg, msto_ctrl and msto_dpath.
//
// The table holds SLOTS one-shot timeouts and takes one input word at a time.
// The slot memories have one read port, so the controller visits one slot per
// clock cycle while the scan is not held by a full output register. An arm
// word visits the slots in order up to the first free one (all of them when
// the table is full) and yields one reply. A tick word visits every slot and
// decrements each busy one, then sends the last expiry event, when there is
// one, from the flush state; events leave in slot order and at most four per
// tick. A stalled output stream holds the table whenever the arm reply, a
// second expiry event found during the scan or the final expiry event meets
// an output register that is still full. A word is accepted only while the
// table is idle; a result waiting at the output does not block the next word.
module multi_slot_timeout_table_top
#(
    parameter int SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // duration[31:0], handler_id[47:32], param_tag[79:48]
    input  logic [0:0]  s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // accepted[0], slot[2:1], out_handler[18:3],
                                       // out_tag[50:19], zero[55:51]
    output logic [0:0]  m_axis_tuser,  // kind[0]
    output logic        m_axis_tlast
);

    msto_pkg::cmd_t  cmd;
    msto_pkg::stat_t stat;

    logic                        out_kind;
    logic                        out_accepted;
    logic [msto_pkg::SLOT_W-1:0] out_slot;
    logic [msto_pkg::HND_W-1:0]  out_handler;
    logic [msto_pkg::TAG_W-1:0]  out_tag;

    // Scan sequencer.
    msto_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Slot storage and result path.
    msto_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_func      (s_axis_tuser[0]),
        .in_duration  (s_axis_tdata[31:0]),
        .in_handler   (s_axis_tdata[47:32]),
        .in_tag       (s_axis_tdata[79:48]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_kind     (out_kind),
        .out_accepted (out_accepted),
        .out_slot     (out_slot),
        .out_handler  (out_handler),
        .out_tag      (out_tag),
        .out_last     (m_axis_tlast)
    );

    // Pack the result word.
    assign m_axis_tdata = {5'b00000, out_tag, out_handler, out_slot, out_accepted};
    assign m_axis_tuser = out_kind;

endmodule
